// ----- src/bblru_pkg.sv -----
// Shared types, codes and constants of the byte-budget LRU page cache.
// Used by bblru_cell, bblru_chain and the top level; depends on nothing.
`default_nettype none
package bblru_pkg;

  localparam int PAGE_W     = 24;
  localparam int BYTES_W    = 16;
  localparam int BUDGET_W   = 24;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int DEF_ENTRIES = 16;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd65536;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  // One cache entry as held in a cell.
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  // Chain operations, applied to every cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_DROP   = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PAGE_W-1:0] key_page;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/bblru_cell.sv -----
// One cell of the recency chain: holds the entry at one recency position.
// Depends on bblru_pkg.
`default_nettype none
module bblru_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bblru_pkg::cell_ctl_t ctl,
  input  bblru_pkg::entry_t    prev_ent,
  input  bblru_pkg::entry_t    next_ent,
  input  bblru_pkg::entry_t    head_ent,
  input  wire                  below_in,
  output bblru_pkg::entry_t    ent_o,
  output logic                 match_o,
  output logic                 below_o,
  output logic                 tail_o
);

  logic                          valid_r, valid_nxt;
  logic [bblru_pkg::PAGE_W-1:0]  page_r, page_nxt;
  logic [bblru_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;

  // Match against the looked-up page, and the oldest-valid (tail) flag.
  assign match_o = valid_r && (page_r == ctl.key_page);
  assign below_o = below_in || match_o;
  assign tail_o  = valid_r && !next_ent.valid;
  assign ent_o   = '{valid: valid_r, page: page_r, bytes: bytes_r};

  // Next content from the neighbours according to the chain operation.
  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    bytes_nxt = bytes_r;
    case (ctl.op)
      bblru_pkg::OP_HOLD: begin
      end
      bblru_pkg::OP_INSERT: begin
        valid_nxt = prev_ent.valid;
        page_nxt  = prev_ent.page;
        bytes_nxt = prev_ent.bytes;
      end
      bblru_pkg::OP_REMOVE: begin
        if (below_o) begin
          valid_nxt = next_ent.valid;
          page_nxt  = next_ent.page;
          bytes_nxt = next_ent.bytes;
        end
      end
      bblru_pkg::OP_DROP: begin
        if (tail_o) begin
          valid_nxt = 1'b0;
        end
      end
      bblru_pkg::OP_ROTATE: begin
        if (tail_o) begin
          valid_nxt = head_ent.valid;
          page_nxt  = head_ent.page;
          bytes_nxt = head_ent.bytes;
        end else begin
          valid_nxt = next_ent.valid;
          page_nxt  = next_ent.page;
          bytes_nxt = next_ent.bytes;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bit is control state; payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    bytes_r <= bytes_nxt;
  end

endmodule
`default_nettype wire

// ----- src/bblru_chain.sv -----
// Row of recency cells, most recent at position zero, with lookup and tail read-out.
// Depends on bblru_pkg and bblru_cell.
`default_nettype none
module bblru_chain #(
  parameter int ENTRIES = bblru_pkg::DEF_ENTRIES
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  bblru_pkg::cell_ctl_t           ctl,
  input  bblru_pkg::entry_t              new_ent,
  output logic                           hit,
  output logic [bblru_pkg::BYTES_W-1:0]  hit_bytes,
  output bblru_pkg::entry_t              head_ent,
  output bblru_pkg::entry_t              tail_ent,
  output logic [ENTRIES-1:0]             valid_vec
);

  bblru_pkg::entry_t ent   [ENTRIES];
  logic              match [ENTRIES];
  logic              below [ENTRIES];
  logic              tail  [ENTRIES];

  assign head_ent = ent[0];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      bblru_pkg::entry_t prev_w, next_w;
      logic              below_w;
      if (gi == 0) begin : g_first
        assign prev_w  = new_ent;
        assign below_w = 1'b0;
      end else begin : g_mid
        assign prev_w  = ent[gi-1];
        assign below_w = below[gi-1];
      end
      if (gi == ENTRIES-1) begin : g_last
        assign next_w = '0;
      end else begin : g_inner
        assign next_w = ent[gi+1];
      end
      bblru_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .prev_ent (prev_w),
        .next_ent (next_w),
        .head_ent (ent[0]),
        .below_in (below_w),
        .ent_o    (ent[gi]),
        .match_o  (match[gi]),
        .below_o  (below[gi]),
        .tail_o   (tail[gi])
      );
      assign valid_vec[gi] = ent[gi].valid;
    end
  endgenerate

  // Page numbers are unique and the tail is unique, so plain OR selects.
  always_comb begin
    hit       = 1'b0;
    hit_bytes = '0;
    tail_ent  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit       = hit | match[i];
      hit_bytes = hit_bytes | (match[i] ? ent[i].bytes : '0);
      tail_ent  = tail_ent | (tail[i] ? ent[i] : '0);
    end
  end

endmodule
`default_nettype wire

// ----- src/byte_budget_lru_page_cache_top.sv -----
// Byte-budget LRU page cache controller: sequencer, byte total and result register.
// A request is looked up in the cycle after acceptance; results leave through a registered output.
// Throughput: one request at a time; the sequencer steps the recency chain once a cycle
// while the result side is not holding off a waiting result.
// Reset (rst_n low, synchronous) empties the cache and sets the budget to 65536 bytes.
`default_nettype none
module byte_budget_lru_page_cache_top #(
  parameter int ENTRIES = bblru_pkg::DEF_ENTRIES
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [23:0] cfg_wr_data,   // cache_budget_bytes
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,      // page_num[23:0], page_bytes[39:24]
  input  wire  [1:0]  in_tuser,      // cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,     // out_page[23:0], out_bytes[39:24]
  output logic [1:0]  out_tuser,     // kind
  output logic        out_tlast      // last
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TOT_W = bblru_pkg::BYTES_W + CNT_W;
  localparam int CMP_W = ((TOT_W > bblru_pkg::BUDGET_W) ? TOT_W : bblru_pkg::BUDGET_W) + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_EVICT = 4'b0100,
    S_SYNC  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bblru_pkg::CMD_W-1:0]     cmd_r;
  logic [bblru_pkg::PAGE_W-1:0]    pg_r;
  logic [bblru_pkg::BYTES_W-1:0]   by_r;
  logic                            clean_r, clean_nxt;
  logic                            emitted_r, emitted_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                k_r, k_nxt;
  logic [TOT_W-1:0]                total_r, total_nxt;
  logic [bblru_pkg::BUDGET_W-1:0]  budget_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [bblru_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [bblru_pkg::PAGE_W-1:0]    out_page_r, out_page_nxt;
  logic [bblru_pkg::BYTES_W-1:0]   out_bytes_r, out_bytes_nxt;
  logic                            out_last_r, out_last_nxt;

  bblru_pkg::cell_ctl_t            ctl;
  logic                            hit;
  logic [bblru_pkg::BYTES_W-1:0]   hit_bytes;
  bblru_pkg::entry_t               head_ent, tail_ent;
  logic [ENTRIES-1:0]              valid_vec;

  logic                            in_acc, ofree, need, more, flush_last;
  logic [CNT_W-1:0]                cnt_less;
  logic [TOT_W-1:0]                tot_less;

  bblru_chain #(.ENTRIES(ENTRIES)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .new_ent   ('{valid: 1'b1, page: pg_r, bytes: by_r}),
    .hit       (hit),
    .hit_bytes (hit_bytes),
    .head_ent  (head_ent),
    .tail_ent  (tail_ent),
    .valid_vec (valid_vec)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign ofree      = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bytes_r, out_page_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Eviction test now, and after flushing the current tail.
  assign cnt_less = count_r - CNT_W'(1);
  assign tot_less = total_r - TOT_W'(tail_ent.bytes);
  assign need = (count_r >= FULL) ||
                (CMP_W'(total_r) + CMP_W'(by_r) > CMP_W'(budget_r));
  assign more = (cnt_less >= FULL) ||
                (CMP_W'(tot_less) + CMP_W'(by_r) > CMP_W'(budget_r));
  assign flush_last = !(more && ((cnt_less != '0) || !clean_r));

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    clean_nxt     = clean_r;
    emitted_nxt   = emitted_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_page_nxt  = out_page_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    ctl.op        = bblru_pkg::OP_HOLD;
    ctl.key_page  = pg_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt   = S_MATCH;
          clean_nxt   = 1'b0;
          emitted_nxt = 1'b0;
          k_nxt       = '0;
        end
      end
      S_MATCH: begin
        if (ofree) begin
          if (cmd_r == bblru_pkg::CMD_SYNC) begin
            state_nxt = S_SYNC;
          end else if (cmd_r == bblru_pkg::CMD_READ) begin
            out_valid_nxt = 1'b1;
            out_page_nxt  = pg_r;
            if (hit) begin
              out_kind_nxt  = bblru_pkg::KIND_HIT;
              out_bytes_nxt = hit_bytes;
              out_last_nxt  = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              out_kind_nxt  = bblru_pkg::KIND_MISS;
              out_bytes_nxt = by_r;
              out_last_nxt  = !(need && (count_r != '0));
              clean_nxt     = 1'b1;
              emitted_nxt   = 1'b1;
              state_nxt     = S_EVICT;
            end
          end else if (cmd_r == bblru_pkg::CMD_WRITE) begin
            // Any older copy of the page is dropped silently.
            if (hit) begin
              ctl.op    = bblru_pkg::OP_REMOVE;
              count_nxt = cnt_less;
              total_nxt = total_r - TOT_W'(hit_bytes);
            end
            state_nxt = S_EVICT;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = bblru_pkg::KIND_DONE;
            out_page_nxt  = '0;
            out_bytes_nxt = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_EVICT: begin
        if (ofree) begin
          if (!need) begin
            ctl.op    = bblru_pkg::OP_INSERT;
            count_nxt = count_r + CNT_W'(1);
            total_nxt = total_r + TOT_W'(by_r);
            if (!emitted_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = bblru_pkg::KIND_DONE;
              out_page_nxt  = '0;
              out_bytes_nxt = '0;
              out_last_nxt  = 1'b1;
            end
            state_nxt = S_IDLE;
          end else if (count_r != '0) begin
            // Flush the least recent page.
            ctl.op        = bblru_pkg::OP_DROP;
            count_nxt     = cnt_less;
            total_nxt     = tot_less;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = bblru_pkg::KIND_FLUSH;
            out_page_nxt  = tail_ent.page;
            out_bytes_nxt = tail_ent.bytes;
            out_last_nxt  = flush_last;
            emitted_nxt   = 1'b1;
          end else begin
            // Page alone exceeds the budget: a written page goes straight out.
            if (!clean_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = bblru_pkg::KIND_FLUSH;
              out_page_nxt  = pg_r;
              out_bytes_nxt = by_r;
              out_last_nxt  = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_SYNC: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          if (k_r < count_r) begin
            ctl.op        = bblru_pkg::OP_ROTATE;
            k_nxt         = k_r + CNT_W'(1);
            out_kind_nxt  = bblru_pkg::KIND_FLUSH;
            out_page_nxt  = head_ent.page;
            out_bytes_nxt = head_ent.bytes;
            out_last_nxt  = 1'b0;
          end else begin
            out_kind_nxt  = bblru_pkg::KIND_DONE;
            out_page_nxt  = '0;
            out_bytes_nxt = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      budget_r    <= bblru_pkg::BUDGET_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      pg_r  <= in_tdata[23:0];
      by_r  <= in_tdata[39:24];
    end
    clean_r     <= clean_nxt;
    emitted_r   <= emitted_nxt;
    k_r         <= k_nxt;
    out_kind_r  <= out_kind_nxt;
    out_page_r  <= out_page_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Entry count tracks the cells that hold a page.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_vec)))
    else $error("entry count differs from valid cells");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count beyond capacity");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> total_r == '0)
    else $error("byte total non-zero with empty cache");

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_MATCH)
    else $error("accepted request not looked up");

endmodule
`default_nettype wire
